@@ rtl/core/stq_pkg.sv @@
// Package for the sorted timer queue: operation and status codes, the cell control types,
// the controller states and the default sizes.
// No dependencies; every other file of the block imports it.
package stq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TIME_WIDTH  = 48;
    localparam int ID_W            = 6;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 3;
    localparam int DELAY_W         = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SCHEDULED = 3'd0,
        STAT_CANCELLED = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_EXPIRED   = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_IDLE      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_DRAIN
    } ctl_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_op_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   key_id;
    } cell_ctrl_t;

endpackage

@@ rtl/core/stq_cell.sv @@
// One cell of the sorted timer chain: a valid bit, a deadline and an id.
// Depends on stq_pkg; neighbors are wired together by sorted_timer_queue_top.
module stq_cell
    import stq_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [TIME_WIDTH-1:0] key_deadline,
    input  logic [TIME_WIDTH-1:0] now_time,
    input  logic                  left_valid,
    input  logic [TIME_WIDTH-1:0] left_deadline,
    input  logic [ID_W-1:0]       left_id,
    input  logic                  left_gt,
    input  logic                  right_valid,
    input  logic [TIME_WIDTH-1:0] right_deadline,
    input  logic [ID_W-1:0]       right_id,
    input  logic                  hit_in,
    output logic                  valid,
    output logic [TIME_WIDTH-1:0] deadline,
    output logic [ID_W-1:0]       id,
    output logic                  gt,
    output logic                  hit_out,
    output logic                  due
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [TIME_WIDTH-1:0] deadline_reg;
    logic [TIME_WIDTH-1:0] deadline_next;
    logic [ID_W-1:0]       id_reg;
    logic [ID_W-1:0]       id_next;

    // The new entry goes in front of this cell's entry, or into an empty cell.
    assign gt      = !valid_reg || (key_deadline < deadline_reg);
    assign hit_out = hit_in || (valid_reg && (id_reg == ctrl.key_id));
    assign due     = valid_reg && (deadline_reg <= now_time);

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign id       = id_reg;

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        id_next       = id_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (gt && left_gt)
                begin
                    valid_next    = left_valid;
                    deadline_next = left_deadline;
                    id_next       = left_id;
                end
                else if (gt)
                begin
                    valid_next    = 1'b1;
                    deadline_next = key_deadline;
                    id_next       = ctrl.key_id;
                end
            end
            CELL_REMOVE:
            begin
                if (hit_out)
                begin
                    valid_next    = right_valid;
                    deadline_next = right_deadline;
                    id_next       = right_id;
                end
            end
            CELL_POP:
            begin
                valid_next    = right_valid;
                deadline_next = right_deadline;
                id_next       = right_id;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        id_reg       <= id_next;
    end

endmodule

@@ rtl/core/sorted_timer_queue_top.sv @@
// Sorted timer queue: a start/busy command port, a chain of stq_cell entries and a result strobe.
// The command is latched into the execute state, and the result registers load from that state;
// the receiver cannot stall. A new command is accepted only while idle. Schedule, cancel and
// unused codes give one result; a tick that expires n timers gives n results (one pop of the
// chain head per cycle), and an idle tick gives one result.
// Reset (rst_n, asynchronous) empties the chain, sets the time and the id counter to zero.
module sorted_timer_queue_top
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     operation,
    input  logic [DELAY_W-1:0]  delay_ticks,
    input  logic [ID_W-1:0]     cancel_id,
    output logic                result_valid,
    output logic [ID_W-1:0]     timer_id,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    // The deadline sum must hold both the time and the delay plus a carry, so that
    // saturation at the largest time value can be detected from the upper bits.
    localparam int SUM_W = ((TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W) + 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    // Controller state and the latched command.
    ctl_state_t            state_reg;
    ctl_state_t            state_next;
    op_t                   op_reg;
    op_t                   op_next;
    logic [DELAY_W-1:0]    delay_reg;
    logic [DELAY_W-1:0]    delay_next;
    logic [ID_W-1:0]       cid_reg;
    logic [ID_W-1:0]       cid_next;
    logic [ID_W-1:0]       next_id_reg;
    logic [ID_W-1:0]       next_id_next;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] time_next;

    // Result registers; the strobe is high for exactly one cycle per result.
    logic                  result_valid_reg;
    logic                  result_valid_next;
    logic [ID_W-1:0]       timer_id_reg;
    logic [ID_W-1:0]       timer_id_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  accept;
    logic [SUM_W-1:0]      deadline_sum;
    logic [TIME_WIDTH-1:0] sched_deadline;
    logic                  queue_full;
    logic                  head_due;
    logic                  second_due;
    logic                  cancel_found;
    cell_ctrl_t            cell_ctrl;

    // Chain signals: index i belongs to cell i; hit has one extra slot for the chain input.
    logic                  vld  [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] dl   [QUEUE_DEPTH];
    logic [ID_W-1:0]       ids  [QUEUE_DEPTH];
    logic                  gt   [QUEUE_DEPTH];
    logic                  due  [QUEUE_DEPTH];
    logic                  hit  [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] vld_vec;

    assign accept = start && (state_reg == CTL_IDLE);
    assign busy   = (state_reg != CTL_IDLE);

    // Saturating deadline: current time plus the delay, clamped to the largest time.
    assign deadline_sum   = SUM_W'(time_reg) + SUM_W'(delay_reg);
    assign sched_deadline = (|deadline_sum[SUM_W-1:TIME_WIDTH]) ? TIME_MAX
                                                                : deadline_sum[TIME_WIDTH-1:0];

    // Entries fill the chain from cell zero, so the last cell being valid means full.
    assign queue_full   = vld[QUEUE_DEPTH-1];
    assign head_due     = due[0];
    assign second_due   = due[1];
    assign cancel_found = hit[QUEUE_DEPTH];
    assign hit[0]       = 1'b0;

    // The chain of cells. Each cell looks at its left neighbor for inserts and at its
    // right neighbor for removals and pops; the end cells see an empty neighbor.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                  l_valid;
        logic [TIME_WIDTH-1:0] l_deadline;
        logic [ID_W-1:0]       l_id;
        logic                  l_gt;
        logic                  r_valid;
        logic [TIME_WIDTH-1:0] r_deadline;
        logic [ID_W-1:0]       r_id;

        if (i == 0)
        begin : g_left_end
            assign l_valid    = 1'b0;
            assign l_deadline = '0;
            assign l_id       = '0;
            assign l_gt       = 1'b0;
        end
        else
        begin : g_left
            assign l_valid    = vld[i-1];
            assign l_deadline = dl[i-1];
            assign l_id       = ids[i-1];
            assign l_gt       = gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_right_end
            assign r_valid    = 1'b0;
            assign r_deadline = '0;
            assign r_id       = '0;
        end
        else
        begin : g_right
            assign r_valid    = vld[i+1];
            assign r_deadline = dl[i+1];
            assign r_id       = ids[i+1];
        end

        stq_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (cell_ctrl),
            .key_deadline   (sched_deadline),
            .now_time       (time_reg),
            .left_valid     (l_valid),
            .left_deadline  (l_deadline),
            .left_id        (l_id),
            .left_gt        (l_gt),
            .right_valid    (r_valid),
            .right_deadline (r_deadline),
            .right_id       (r_id),
            .hit_in         (hit[i]),
            .valid          (vld[i]),
            .deadline       (dl[i]),
            .id             (ids[i]),
            .gt             (gt[i]),
            .hit_out        (hit[i+1]),
            .due            (due[i])
        );

        assign vld_vec[i] = vld[i];
    end

    // Next state. A tick stays in the drain state while the next entry is also due.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (start)
                begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC, CTL_DRAIN:
            begin
                if ((op_reg == OP_TICK) && head_due && second_due)
                begin
                    state_next = CTL_DRAIN;
                end
                else
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // Outputs of the controller: command latch, time update, cell control and results.
    always_comb
    begin
        op_next           = op_reg;
        delay_next        = delay_reg;
        cid_next          = cid_reg;
        next_id_next      = next_id_reg;
        time_next         = time_reg;
        cell_ctrl.op      = CELL_HOLD;
        cell_ctrl.key_id  = cid_reg;
        result_valid_next = 1'b0;
        timer_id_next     = timer_id_reg;
        status_next       = status_reg;
        last_next         = last_reg;

        case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(operation);
                    delay_next = delay_ticks;
                    cid_next   = cancel_id;
                    // The time advances at acceptance, so the expiry check sees the new time.
                    if ((op_t'(operation) == OP_TICK) && (time_reg != TIME_MAX))
                    begin
                        time_next = time_reg + 1'b1;
                    end
                end
            end
            CTL_EXEC, CTL_DRAIN:
            begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                timer_id_next     = '0;
                status_next       = STAT_IDLE;
                case (op_reg)
                    OP_SCHEDULE:
                    begin
                        if (queue_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            cell_ctrl.op     = CELL_INSERT;
                            cell_ctrl.key_id = next_id_reg;
                            timer_id_next    = next_id_reg;
                            status_next      = STAT_SCHEDULED;
                            next_id_next     = ID_W'(next_id_reg + 1'b1);
                        end
                    end
                    OP_CANCEL:
                    begin
                        cell_ctrl.op  = CELL_REMOVE;
                        timer_id_next = cid_reg;
                        status_next   = cancel_found ? STAT_CANCELLED : STAT_NOT_FOUND;
                    end
                    OP_TICK:
                    begin
                        if (head_due)
                        begin
                            cell_ctrl.op  = CELL_POP;
                            timer_id_next = ids[0];
                            status_next   = STAT_EXPIRED;
                            last_next     = !second_due;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_IDLE;
                    end
                endcase
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= CTL_IDLE;
            next_id_reg      <= '0;
            time_reg         <= '0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            next_id_reg      <= next_id_next;
            time_reg         <= time_next;
            result_valid_reg <= result_valid_next;
            last_reg         <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        delay_reg    <= delay_next;
        cid_reg      <= cid_next;
        timer_id_reg <= timer_id_next;
        status_reg   <= status_next;
    end

    assign result_valid = result_valid_reg;
    assign timer_id     = timer_id_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // The controller returns to idle exactly when the final result of an item goes out.
    a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("busy fell without a final result");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final result while the controller is still busy");

    // An expired result that is not the final one means the drain continues.
    a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> (busy && (status == STAT_EXPIRED)))
        else $error("non-final result outside a tick drain");

    // Valid entries always form a packed run starting at cell zero.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (((vld_vec + 1'b1) & vld_vec) == '0))
        else $error("gap in the timer chain");

endmodule
